@@ hw/rtl/fdm_pkg.sv @@
// Shared types and codes for the FIFO with delete-minimum.
`timescale 1ns / 1ps

package fdm_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned CmdW = 2;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_DELMIN = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Result of the shared value comparator.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

@@ hw/rtl/fdm_mem.sv @@
// Entry storage: one write port, one registered read port.
`timescale 1ns / 1ps

module fdm_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [fdm_pkg::ValW-1:0] wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [fdm_pkg::ValW-1:0] rdata_o
);
  import fdm_pkg::*;

  logic [ValW-1:0] mem_q [DEPTH];
  logic [ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/fdm_cmp.sv @@
// Shared signed comparator used by both delete-minimum passes.
`timescale 1ns / 1ps

module fdm_cmp (
  input  logic [fdm_pkg::ValW-1:0] a_i,
  input  logic [fdm_pkg::ValW-1:0] b_i,
  output fdm_pkg::cmp_res_t        res_o
);
  import fdm_pkg::*;

  assign res_o.lt = $signed(a_i) < $signed(b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

@@ hw/rtl/fifo_with_delete_minimum.sv @@
// Top level: circular-buffer FIFO with pop, clear and delete-minimum sequencer.
`timescale 1ns / 1ps

// Bounded FIFO of signed 32-bit words held in a circular buffer of DEPTH
// entries. Each input word carries one command and yields one result word with
// the status, the count after the command and the head value (zero when empty).
// The block takes one command at a time. Push, pop and clear run from
// acceptance through the execute, head-read and head-wait states to the result.
// Delete-minimum walks the stored entries twice through the single read port of
// the buffer and one shared comparator: a scan for the minimum, then a compaction
// pass that rewrites the surviving entries in order. The input is ready again as
// soon as the result sits in the output register.

module fifo_with_delete_minimum #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] command, [33:2] push_value, [39:34] zero
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [CW+1:2] entry_count, [CW+33:CW+2] head_value, rest zero
  output logic [((34+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata_o
);
  import fdm_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam int unsigned OUT_W = ((StatusW+CW+ValW+7)/8)*8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MIN,
    S_CMPCT,
    S_RDH,
    S_HWAIT
  } state_e;

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  state_e           state_q;
  cmd_e             cmd_q;
  logic [ValW-1:0]  val_q;
  logic [AW-1:0]    head_q, tail_q, rd_ptr_q, wr_ptr_q;
  logic [CW-1:0]    cnt_q, issue_q, kept_q;
  logic             pend_q;
  logic [ValW-1:0]  min_q;
  logic             min_vld_q;
  status_e          status_q;
  logic             out_vld_q;
  logic [OUT_W-1:0] out_data_q;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [ValW-1:0]  mem_wdata, rdata;
  cmp_res_t         cmp;
  logic             issue, full, in_acc, out_free;

  assign issue    = (issue_q != cnt_q);
  assign full     = (cnt_q == CW'(DEPTH));
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_q;
    mem_wdata = rdata;
    if (state_q == S_EXEC) begin
      mem_we    = (cmd_q == CMD_PUSH) && !full;
      mem_waddr = tail_q;
      mem_wdata = val_q;
    end else if (state_q == S_CMPCT) begin
      // keep every entry that differs from the minimum
      mem_we = pend_q && !cmp.eq;
    end
    mem_raddr = (state_q == S_RDH || state_q == S_HWAIT) ? head_q : rd_ptr_q;
  end

  fdm_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(rdata)
  );

  fdm_cmp u_cmp (
    .a_i  (rdata),
    .b_i  (min_q),
    .res_o(cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmd_q     <= CMD_PUSH;
      head_q    <= '0;
      tail_q    <= '0;
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      cnt_q     <= '0;
      issue_q   <= '0;
      kept_q    <= '0;
      pend_q    <= 1'b0;
      min_vld_q <= 1'b0;
      status_q  <= ST_DONE;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && m_axis_tready_i && state_q != S_HWAIT) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q   <= cmd_e'(s_axis_tdata_i[CmdW-1:0]);
            val_q   <= s_axis_tdata_i[CmdW +: ValW];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_q == CMD_PUSH) begin
            state_q <= S_RDH;
            if (full) begin
              status_q <= ST_FULL;
            end else begin
              status_q <= ST_DONE;
              tail_q   <= inc_ptr(tail_q);
              cnt_q    <= cnt_q + 1'b1;
            end
          end else if (cnt_q == '0) begin
            status_q <= ST_EMPTY;
            state_q  <= S_RDH;
          end else begin
            status_q <= ST_DONE;
            unique case (cmd_q)
              CMD_POP: begin
                head_q  <= inc_ptr(head_q);
                cnt_q   <= cnt_q - 1'b1;
                state_q <= S_RDH;
              end
              CMD_CLEAR: begin
                tail_q  <= head_q;
                cnt_q   <= '0;
                state_q <= S_RDH;
              end
              default: begin
                rd_ptr_q  <= head_q;
                issue_q   <= '0;
                pend_q    <= 1'b0;
                min_vld_q <= 1'b0;
                state_q   <= S_MIN;
              end
            endcase
          end
        end
        S_MIN: begin
          if (issue) begin
            rd_ptr_q <= inc_ptr(rd_ptr_q);
            issue_q  <= issue_q + 1'b1;
          end
          pend_q <= issue;
          if (pend_q && (!min_vld_q || cmp.lt)) begin
            min_q     <= rdata;
            min_vld_q <= 1'b1;
          end
          if (!issue && !pend_q) begin
            // rewind for the compaction pass
            rd_ptr_q <= head_q;
            wr_ptr_q <= head_q;
            issue_q  <= '0;
            kept_q   <= '0;
            state_q  <= S_CMPCT;
          end
        end
        S_CMPCT: begin
          if (issue) begin
            rd_ptr_q <= inc_ptr(rd_ptr_q);
            issue_q  <= issue_q + 1'b1;
          end
          pend_q <= issue;
          if (mem_we) begin
            wr_ptr_q <= inc_ptr(wr_ptr_q);
            kept_q   <= kept_q + 1'b1;
          end
          if (!issue && !pend_q) begin
            cnt_q   <= kept_q;
            tail_q  <= wr_ptr_q;
            state_q <= S_RDH;
          end
        end
        S_RDH: begin
          state_q <= S_HWAIT;
        end
        S_HWAIT: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_data_q <= OUT_W'({(cnt_q == '0) ? ValW'(0) : rdata, cnt_q,
                                  StatusW'(status_q)});
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_kept_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMPCT) |-> (kept_q <= issue_q))
    else $error("compaction write pointer ran ahead of read pointer");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cmd_q == CMD_PUSH && !full)
      |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("push with room did not grow the queue");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MIN || state_q == S_CMPCT) |-> !s_axis_tready_o)
    else $error("input ready during delete-minimum");

endmodule
